// File: hdl/tfc_pkg.sv
package tfc_pkg;

	localparam int unsigned CountW = 17;
	localparam int unsigned SumW = 32;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 17;

	localparam logic [CountW-1:0] COUNT_MAX = 17'd65543;
	localparam logic [CountW-1:0] HEADER_BYTES = 17'd7;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_MIN_FRAME = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_STATUS_ID = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_STATUS_LEN = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ATTITUDE_ID = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ATTITUDE_LEN = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_POINTING_ID = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_POINTING_LEN = 3'd6;

	// Verdict codes.
	localparam logic [2:0] VERDICT_OK = 3'd0;
	localparam logic [2:0] VERDICT_SHORT = 3'd1;
	localparam logic [2:0] VERDICT_SIZE = 3'd2;
	localparam logic [2:0] VERDICT_UNKNOWN_ID = 3'd3;
	localparam logic [2:0] VERDICT_BAD_LENGTH = 3'd4;
	localparam logic [2:0] VERDICT_CHECKSUM = 3'd5;

	// Message kinds.
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_ATTITUDE = 2'd1;
	localparam logic [1:0] KIND_POINTING = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef struct packed {
		logic [CountW-1:0] min_frame_bytes;
		logic [7:0] status_msg_id;
		logic [15:0] status_length;
		logic [7:0] attitude_id;
		logic [15:0] attitude_length;
		logic [7:0] pointing_id;
		logic [15:0] pointing_length;
	} cfg_t;

	// Everything the verdict logic needs about a frame that just closed.
	typedef struct packed {
		logic valid;
		logic [CountW-1:0] count;
		logic [SumW-1:0] sum;
		logic [15:0] received;
		logic [15:0] length_field;
		logic [7:0] id_byte;
	} frame_end_t;

endpackage

// File: hdl/tfc_cfg_regs.sv
module tfc_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [tfc_pkg::CfgIdxW-1:0] cfg_index,
	input logic [tfc_pkg::CfgDataW-1:0] cfg_data,
	output tfc_pkg::cfg_t cfg
);
	import tfc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_frame_bytes <= HEADER_BYTES;
			cfg_q.status_msg_id <= 8'd0;
			cfg_q.status_length <= 16'd0;
			cfg_q.attitude_id <= 8'd1;
			cfg_q.attitude_length <= 16'd0;
			cfg_q.pointing_id <= 8'd2;
			cfg_q.pointing_length <= 16'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MIN_FRAME: cfg_q.min_frame_bytes <= cfg_data;
				REG_STATUS_ID: cfg_q.status_msg_id <= cfg_data[7:0];
				REG_STATUS_LEN: cfg_q.status_length <= cfg_data[15:0];
				REG_ATTITUDE_ID: cfg_q.attitude_id <= cfg_data[7:0];
				REG_ATTITUDE_LEN: cfg_q.attitude_length <= cfg_data[15:0];
				REG_POINTING_ID: cfg_q.pointing_id <= cfg_data[7:0];
				REG_POINTING_LEN: cfg_q.pointing_length <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/tfc_frame_acc.sv
module tfc_frame_acc (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] byte_value,
	input logic last_byte,
	input logic out_free,
	output tfc_pkg::frame_end_t frame_end
);
	import tfc_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic advance;

	logic [CountW-1:0] pos_q;
	logic [SumW-1:0] sum_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic [15:0] length_q;
	logic [7:0] id_q;
	logic odd_q;

	logic [SumW-1:0] addend;
	logic [SumW-1:0] sum_next;
	logic odd_next;
	logic [15:0] length_next;
	logic [7:0] id_next;
	logic [CountW-1:0] pos_next;

	// A closing byte waits in the input register while the result register is full.
	assign advance = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	// The byte two places back leaves the delay line and joins the sum.
	always_comb begin
		addend = '0;
		odd_next = odd_q;
		if (pos_q >= 17'd2) begin
			if (!odd_q) begin
				addend = {16'd0, held0_q ^ 8'hFF, 8'h00};
			end else begin
				addend = {24'd0, held0_q ^ 8'hFF};
			end
			odd_next = !odd_q;
		end
		sum_next = sum_q + addend;

		length_next = length_q;
		id_next = id_q;
		if (pos_q == 17'd2) begin
			length_next = {length_q[15:8], byte_s1};
		end else if (pos_q == 17'd3) begin
			length_next = {byte_s1, length_q[7:0]};
		end else if (pos_q == 17'd4) begin
			id_next = byte_s1;
		end

		pos_next = (pos_q < COUNT_MAX) ? pos_q + 17'd1 : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			held0_q <= '0;
			held1_q <= '0;
			length_q <= '0;
			id_q <= '0;
			odd_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q <= '0;
				sum_q <= '0;
				held0_q <= '0;
				held1_q <= '0;
				length_q <= '0;
				id_q <= '0;
				odd_q <= 1'b0;
			end else begin
				pos_q <= pos_next;
				sum_q <= sum_next;
				held0_q <= held1_q;
				held1_q <= byte_s1;
				length_q <= length_next;
				id_q <= id_next;
				odd_q <= odd_next;
			end
		end
	end

	always_comb begin
		frame_end.valid = advance && last_s1;
		frame_end.count = pos_next;
		frame_end.sum = odd_next ? sum_next + 32'h0000_00FF : sum_next;
		frame_end.received = {byte_s1, held1_q};
		frame_end.length_field = length_next;
		frame_end.id_byte = id_next;
	end

endmodule

// File: hdl/tfc_verdict.sv
module tfc_verdict (
	input logic clk,
	input logic arst_n,
	input tfc_pkg::cfg_t cfg,
	input tfc_pkg::frame_end_t frame_end,
	output logic out_free,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] verdict,
	output logic [1:0] message_kind,
	output logic [16:0] frame_bytes,
	output logic [15:0] computed_sum,
	output logic [15:0] received_sum
);
	import tfc_pkg::*;

	logic out_valid_q;
	logic [2:0] verdict_q;
	logic [1:0] kind_q;
	logic [CountW-1:0] count_q;
	logic [15:0] computed_q;
	logic [15:0] received_q;

	logic [16:0] fold1;
	logic [16:0] fold2;
	logic [15:0] computed;
	logic [1:0] kind;
	logic [15:0] want_len;
	logic [CountW-1:0] expected_count;
	logic [2:0] code;

	always_comb begin
		fold1 = {1'b0, frame_end.sum[31:16]} + {1'b0, frame_end.sum[15:0]};
		fold2 = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};
		computed = fold2[15:0];

		kind = KIND_NONE;
		want_len = '0;
		if (frame_end.count >= 17'd5) begin
			if (frame_end.id_byte == cfg.status_msg_id) begin
				kind = KIND_STATUS;
				want_len = cfg.status_length;
			end else if (frame_end.id_byte == cfg.attitude_id) begin
				kind = KIND_ATTITUDE;
				want_len = cfg.attitude_length;
			end else if (frame_end.id_byte == cfg.pointing_id) begin
				kind = KIND_POINTING;
				want_len = cfg.pointing_length;
			end
		end

		expected_count = {1'b0, frame_end.length_field} + HEADER_BYTES;

		priority if (frame_end.count < cfg.min_frame_bytes || frame_end.count < HEADER_BYTES) begin
			code = VERDICT_SHORT;
		end else if (frame_end.count != expected_count) begin
			code = VERDICT_SIZE;
		end else if (kind == KIND_NONE) begin
			code = VERDICT_UNKNOWN_ID;
		end else if (frame_end.length_field != want_len) begin
			code = VERDICT_BAD_LENGTH;
		end else if (computed != frame_end.received) begin
			code = VERDICT_CHECKSUM;
		end else begin
			code = VERDICT_OK;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame_end.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_end.valid) begin
			verdict_q <= code;
			kind_q <= kind;
			count_q <= frame_end.count;
			computed_q <= computed;
			received_q <= frame_end.received;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict = verdict_q;
	assign message_kind = kind_q;
	assign frame_bytes = count_q;
	assign computed_sum = computed_q;
	assign received_sum = received_q;

endmodule

// File: hdl/telemetry_frame_checker_core.sv
// Telemetry frame checker.
// Input channel (in_valid/in_ready) carries one frame byte per item, with
// last_byte marking the final byte. Output channel (out_valid/out_ready)
// carries one verdict item per frame: verdict code, message kind, byte
// count, computed checksum and received checksum.
// Throughput is one byte per cycle while no closing byte is held, set by the
// single running-sum adder that takes one byte per cycle. A byte lands in
// the input register when accepted; as a closing byte leaves it, its verdict
// is registered in the result register. When the receiver stalls, bytes
// that do not close a frame keep flowing; a closing byte holds in the input
// register until the result register frees, and in_ready drops only then.
// Configuration is written through cfg_write/cfg_index/cfg_data while the
// block is idle; the user must keep to this, as the block does not enforce
// it. Indexes beyond the register list are ignored. Reset clears the frame
// state and the channel valid flags and loads the register defaults (min
// frame 7 bytes, ids 0, 1 and 2, lengths 0).
module telemetry_frame_checker_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [tfc_pkg::CfgIdxW-1:0] cfg_index,
	input logic [tfc_pkg::CfgDataW-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] byte_value,
	input logic last_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] verdict,
	output logic [1:0] message_kind,
	output logic [16:0] frame_bytes,
	output logic [15:0] computed_sum,
	output logic [15:0] received_sum
);
	import tfc_pkg::*;

	cfg_t cfg;
	frame_end_t frame_end;
	logic out_free;

	tfc_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	tfc_frame_acc u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.last_byte(last_byte),
		.out_free(out_free),
		.frame_end(frame_end)
	);

	tfc_verdict u_verdict (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.frame_end(frame_end),
		.out_free(out_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.message_kind(message_kind),
		.frame_bytes(frame_bytes),
		.computed_sum(computed_sum),
		.received_sum(received_sum)
	);

endmodule

// File: tb/testbench.sv
module testbench;
	import tfc_pkg::*;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned RANDOM_BYTES = 160;
	localparam int unsigned KIND_MIN_BYTES = 5;
	localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic [7:0] value;
		logic last;
	} link_byte_t;

	typedef struct packed {
		logic [2:0] verdict;
		logic [1:0] kind;
		logic [CountW-1:0] count;
		logic [15:0] computed;
		logic [15:0] received;
	} frame_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] byte_value = '0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] verdict;
	logic [1:0] message_kind;
	logic [16:0] frame_bytes;
	logic [15:0] computed_sum;
	logic [15:0] received_sum;

	telemetry_frame_checker_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.message_kind(message_kind),
		.frame_bytes(frame_bytes),
		.computed_sum(computed_sum),
		.received_sum(received_sum)
	);

	// Byte items waiting to be sent and verdicts waiting to come back.
	link_byte_t link_bytes [$];
	frame_verdict_t pending_verdicts [$];

	// Shadow of the configuration registers.
	cfg_t reg_copy;

	// Frame state of the predictor.
	logic [CountW-1:0] seen_count = '0;
	logic [SumW-1:0] run_sum = '0;
	logic [7:0] held [2] = '{8'h00, 8'h00};
	logic [15:0] len_seen = '0;
	logic [7:0] id_seen = '0;
	logic odd_slot = 1'b0;

	int unsigned queued_bytes = 0;
	int unsigned bytes_seen = 0;
	int unsigned frames_seen = 0;
	int unsigned mismatches = 0;
	int unsigned verdict_tally [8] = '{0, 0, 0, 0, 0, 0, 0, 0};
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned ready_left = 0;
	int unsigned idle_cycles = 0;
	link_byte_t next_byte;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] sum_term(input logic [7:0] b, input logic odd_byte);
		if (odd_byte)
			return {24'h0, b ^ 8'hFF};
		return {16'h0, b ^ 8'hFF, 8'h00};
	endfunction

	function automatic logic [15:0] fold16(input logic [31:0] s);
		logic [16:0] c;
		c = s[31:16] + s[15:0];
		c = c[16] + c[15:0];
		return c[15:0];
	endfunction

	// Runs one accepted byte through the predictor; a closing byte yields a verdict.
	task automatic absorb_byte(input logic [7:0] b, input logic last);
		frame_verdict_t res;
		logic [15:0] want_len;
		if (seen_count >= 2) begin
			run_sum += sum_term(held[0], odd_slot);
			odd_slot = ~odd_slot;
		end
		held[0] = held[1];
		held[1] = b;
		case (seen_count)
			17'd2: begin
				len_seen[7:0] = b;
			end
			17'd3: begin
				len_seen[15:8] = b;
			end
			17'd4: begin
				id_seen = b;
			end
			default: ;
		endcase
		if (seen_count < COUNT_MAX)
			seen_count++;
		bytes_seen++;
		if (last) begin
			res.count = seen_count;
			res.computed = fold16(run_sum + (odd_slot ? 32'hFF : 32'h0));
			res.received = {held[1], held[0]};
			res.kind = KIND_NONE;
			want_len = '0;
			if (seen_count >= KIND_MIN_BYTES) begin
				if (id_seen == reg_copy.status_msg_id) begin
					res.kind = KIND_STATUS;
					want_len = reg_copy.status_length;
				end else if (id_seen == reg_copy.attitude_id) begin
					res.kind = KIND_ATTITUDE;
					want_len = reg_copy.attitude_length;
				end else if (id_seen == reg_copy.pointing_id) begin
					res.kind = KIND_POINTING;
					want_len = reg_copy.pointing_length;
				end
			end
			if (seen_count < reg_copy.min_frame_bytes || seen_count < HEADER_BYTES)
				res.verdict = VERDICT_SHORT;
			else if (seen_count != {1'b0, len_seen} + HEADER_BYTES)
				res.verdict = VERDICT_SIZE;
			else if (res.kind == KIND_NONE)
				res.verdict = VERDICT_UNKNOWN_ID;
			else if (len_seen != want_len)
				res.verdict = VERDICT_BAD_LENGTH;
			else if (res.computed != res.received)
				res.verdict = VERDICT_CHECKSUM;
			else
				res.verdict = VERDICT_OK;
			pending_verdicts.push_back(res);
			verdict_tally[res.verdict]++;
			frames_seen++;
			seen_count = '0;
			run_sum = '0;
			held[0] = 8'h00;
			held[1] = 8'h00;
			len_seen = '0;
			id_seen = '0;
			odd_slot = 1'b0;
		end
	endtask

	task automatic check_verdict();
		frame_verdict_t got;
		frame_verdict_t want;
		got.verdict = verdict;
		got.kind = message_kind;
		got.count = frame_bytes;
		got.computed = computed_sum;
		got.received = received_sum;
		if (pending_verdicts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected verdict item: verdict %0d kind %0d bytes %0d sums %h/%h",
					got.verdict, got.kind, got.count, got.computed, got.received);
		end else begin
			want = pending_verdicts.pop_front();
			if (got.verdict !== want.verdict || got.kind !== want.kind ||
					got.count !== want.count || got.computed !== want.computed ||
					got.received !== want.received) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("verdict mismatch: expected verdict %0d kind %0d bytes %0d sums %h/%h",
						want.verdict, want.kind, want.count, want.computed, want.received);
					$display("                  actual   verdict %0d kind %0d bytes %0d sums %h/%h",
						got.verdict, got.kind, got.count, got.computed, got.received);
				end
			end
		end
	endtask

	// Byte driver: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (link_bytes.size() != 0) begin
				next_byte = link_bytes.pop_front();
				in_valid <= 1'b1;
				byte_value <= next_byte.value;
				last_byte <= next_byte.last;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 400) :
						$urandom_range(1, 12);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Verdict receiver: alternating ready and stall runs, now and then a long ready run.
	always @(posedge clk) begin
		if (ready_left == 0) begin
			if (out_ready) begin
				out_ready <= 1'b0;
				ready_left = $urandom_range(1, 6);
			end else begin
				out_ready <= 1'b1;
				ready_left = ($urandom_range(9) == 0) ? 300 : $urandom_range(1, 12);
			end
		end else begin
			ready_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				absorb_byte(byte_value, last_byte);
			if (out_valid && out_ready)
				check_verdict();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == STALL_LIMIT) begin
				$display("no item moved for %0d cycles", STALL_LIMIT);
				$display("testbench failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_MIN_FRAME: reg_copy.min_frame_bytes = data;
			REG_STATUS_ID: reg_copy.status_msg_id = data[7:0];
			REG_STATUS_LEN: reg_copy.status_length = data[15:0];
			REG_ATTITUDE_ID: reg_copy.attitude_id = data[7:0];
			REG_ATTITUDE_LEN: reg_copy.attitude_length = data[15:0];
			REG_POINTING_ID: reg_copy.pointing_id = data[7:0];
			REG_POINTING_LEN: reg_copy.pointing_length = data[15:0];
			default: ;
		endcase
	endtask

	// Writes every register; unused upper data bits carry junk that must be masked.
	task automatic apply_config(input logic [16:0] min_bytes,
			input logic [7:0] sid, input logic [15:0] slen,
			input logic [7:0] aid, input logic [15:0] alen,
			input logic [7:0] pid, input logic [15:0] plen);
		logic [16:0] junk;
		junk = 17'($urandom);
		write_reg(REG_MIN_FRAME, min_bytes);
		write_reg(REG_STATUS_ID, {junk[16:8], sid});
		write_reg(REG_STATUS_LEN, {junk[0], slen});
		write_reg(REG_ATTITUDE_ID, {junk[15:7], aid});
		write_reg(REG_ATTITUDE_LEN, {junk[1], alen});
		write_reg(REG_POINTING_ID, {junk[14:6], pid});
		write_reg(REG_POINTING_LEN, {junk[2], plen});
		write_reg(REG_SPARE, junk);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Header bytes go at their places; a good checksum overwrites the last two bytes.
	task automatic queue_frame(input int unsigned n_bytes, input logic [15:0] len_field,
			input logic [7:0] id, input bit good_sum, input bit fixed = 1'b0,
			input logic [7:0] fill_value = 8'h00);
		logic [7:0] frame [$];
		logic [7:0] b;
		logic [31:0] acc;
		logic [15:0] chk;
		link_byte_t lb;
		int unsigned i;
		for (i = 0; i < n_bytes; i++) begin
			b = fixed ? fill_value : 8'($urandom);
			frame.push_back(b);
		end
		if (n_bytes > 2)
			frame[2] = len_field[7:0];
		if (n_bytes > 3)
			frame[3] = len_field[15:8];
		if (n_bytes > 4)
			frame[4] = id;
		if (good_sum && n_bytes >= 2) begin
			acc = '0;
			for (i = 0; i < n_bytes - 2; i++)
				acc += sum_term(frame[i], i[0]);
			if (n_bytes[0])
				acc += 32'hFF;
			chk = fold16(acc);
			frame[n_bytes - 2] = chk[7:0];
			frame[n_bytes - 1] = chk[15:8];
		end
		for (i = 0; i < n_bytes; i++) begin
			lb.value = frame[i];
			lb.last = (i == n_bytes - 1);
			link_bytes.push_back(lb);
		end
		queued_bytes += n_bytes;
	endtask

	// Mostly well-formed frames for a configured message, the rest broken or noise.
	task automatic queue_random_frame();
		int unsigned pick;
		int unsigned n;
		logic [7:0] id;
		logic [15:0] len;
		logic [15:0] other_len;
		pick = $urandom_range(99);
		case ($urandom_range(2))
			0: begin
				id = reg_copy.status_msg_id;
				len = reg_copy.status_length;
			end
			1: begin
				id = reg_copy.attitude_id;
				len = reg_copy.attitude_length;
			end
			default: begin
				id = reg_copy.pointing_id;
				len = reg_copy.pointing_length;
			end
		endcase
		n = len + 7;
		if (pick < 58) begin
			queue_frame(n, len, id, 1'b1);
		end else if (pick < 66) begin
			if (len >= 4 && $urandom_range(1) == 0)
				n = n - $urandom_range(1, 4);
			else
				n = n + $urandom_range(1, 4);
			queue_frame(n, len, id, 1'b1);
		end else if (pick < 72) begin
			do
				id = 8'($urandom);
			while (id == reg_copy.status_msg_id || id == reg_copy.attitude_id ||
				id == reg_copy.pointing_id);
			queue_frame(n, len, id, 1'b1);
		end else if (pick < 78) begin
			other_len = len ^ 16'($urandom_range(1, 15));
			queue_frame(other_len + 7, other_len, id, 1'b1);
		end else if (pick < 87) begin
			queue_frame(n, len, id, 1'b0);
		end else if (pick < 93) begin
			queue_frame($urandom_range(1, 6), len, id, 1'($urandom_range(1)));
		end else begin
			queue_frame($urandom_range(1, 40), 16'($urandom), 8'($urandom),
				1'($urandom_range(1)));
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (link_bytes.size() != 0 || in_valid || pending_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_random_frames();
		int unsigned start;
		start = queued_bytes;
		while (queued_bytes - start < RANDOM_BYTES)
			queue_random_frame();
		wait_idle();
	endtask

	initial begin
		logic [7:0] shared_id;
		reg_copy.min_frame_bytes = 17'd7;
		reg_copy.status_msg_id = 8'd0;
		reg_copy.status_length = 16'd0;
		reg_copy.attitude_id = 8'd1;
		reg_copy.attitude_length = 16'd0;
		reg_copy.pointing_id = 8'd2;
		reg_copy.pointing_length = 16'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Register defaults: tiny frames, the header boundary, good and bad sums.
		queue_frame(1, 16'h0, 8'h00, 1'b0, 1'b1, 8'hFF);
		queue_frame(2, 16'h0, 8'h00, 1'b0);
		queue_frame(5, 16'h0, 8'h01, 1'b0);
		queue_frame(7, 16'h0, 8'h00, 1'b1, 1'b1, 8'h00);
		queue_frame(7, 16'h0, 8'h02, 1'b0, 1'b1, 8'hFF);
		wait_idle();

		apply_config(17'd7, 8'($urandom), 16'($urandom_range(24)), 8'($urandom),
			16'($urandom_range(24)), 8'($urandom), 16'($urandom_range(24)));
		run_random_frames();

		// A raised minimum turns some well-formed frames into short ones.
		apply_config(17'($urandom_range(8, 30)), 8'($urandom), 16'($urandom_range(24)),
			8'($urandom), 16'($urandom_range(24)), 8'($urandom), 16'($urandom_range(24)));
		run_random_frames();

		// Ids configured alike: status takes priority, then attitude.
		shared_id = 8'($urandom);
		apply_config(17'd7, shared_id, 16'($urandom_range(24)), shared_id,
			16'($urandom_range(24)), shared_id, 16'($urandom_range(24)));
		run_random_frames();
		shared_id = 8'($urandom);
		apply_config(17'd12, ~shared_id, 16'($urandom_range(24)), shared_id,
			16'($urandom_range(24)), shared_id, 16'($urandom_range(24)));
		run_random_frames();

		// Extremes: minimum 65542, all-ones ids and lengths for status and pointing.
		apply_config(17'd65542, 8'hFF, 16'hFFFF, 8'h00, 16'h0000, 8'hFF, 16'hFFFF);
		queue_frame(7, 16'h0, 8'h00, 1'b1);
		queue_frame(3, 16'h0, 8'h00, 1'b0, 1'b1, 8'hFF);
		wait_idle();

		apply_config(17'd7, 8'h00, 16'($urandom_range(24)), 8'hFF, 16'($urandom_range(24)),
			8'($urandom), 16'($urandom_range(24)));
		run_random_frames();

		if (pending_verdicts.size() != 0)
			mismatches++;
		$display("covered %0d bytes in %0d frames over the reset defaults and six written settings",
			bytes_seen, frames_seen);
		$display("verdicts: ok %0d, short %0d, size %0d, unknown id %0d, length %0d, sum %0d",
			verdict_tally[VERDICT_OK], verdict_tally[VERDICT_SHORT],
			verdict_tally[VERDICT_SIZE], verdict_tally[VERDICT_UNKNOWN_ID],
			verdict_tally[VERDICT_BAD_LENGTH], verdict_tally[VERDICT_CHECKSUM]);
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("testbench failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/tfc_pkg.sv
hdl/tfc_cfg_regs.sv
hdl/tfc_frame_acc.sv
hdl/tfc_verdict.sv
hdl/telemetry_frame_checker_core.sv
tb/testbench.sv
